FILE: rtl/scs_pkg.sv
// Shared types, widths and codes for the strided cell sum block.
package scs_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int DIM_W    = 7;   // in_height / in_width
  localparam int STEP_W   = 5;   // step_size / cell_size
  localparam int IDX_W    = 6;   // row, col, out_row, out_col
  localparam int CHAN_W   = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Parameter defaults
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_CELL     = 16;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_IN_HEIGHT = 7'd64;
  localparam logic [DIM_W-1:0]  RST_IN_WIDTH  = 7'd64;
  localparam logic [STEP_W-1:0] RST_STEP_SIZE = 5'd4;
  localparam logic [STEP_W-1:0] RST_CELL_SIZE = 5'd4;

  localparam logic [SUM_W-1:0] SUM_MAX = 24'hFF_FFFF;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CELL  = 1'b1
  } scs_cmd_e;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_IN_HEIGHT = 2'd0,
    REG_IN_WIDTH  = 2'd1,
    REG_STEP_SIZE = 2'd2,
    REG_CELL_SIZE = 2'd3
  } scs_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } scs_state_e;

  // Store port controls
  typedef struct packed {
    logic we;
    logic re;
  } scs_mem_ctl_t;

endpackage

FILE: rtl/strided_cell_sum.sv
// Strided cell sum: top level with stream ports, APB registers and scan control.
//
// The block keeps a MAX_CHANNELS x MAX_HEIGHT x MAX_WIDTH image of 16-bit
// unsigned samples in one synchronous memory (contents undefined after
// reset, no clearing pass). A write word (tuser = 0) stores one sample in
// the cycle it is taken and gives no output; writes outside the store are
// dropped. A cell word (tuser = 1) sums one channel over the cell whose
// rows run from min(out_row*step_size, in_height) up to
// min(start + cell_size, in_height), columns likewise, and returns the
// 24-bit sum (saturating, exact at the default sizes). The memory's single
// read port is the limit: a cell reads one sample per cycle in its scan,
// with setup, drain and hand-off steps around it; an empty cell skips the
// scan and drain steps, going straight to hand-off. The input side is
// ready only between items, and the output register lets a new word be
// taken while the last sum waits for the sink. Writes always finish before
// the next cell starts reading, so the store needs no forwarding.
// Registers (byte address): in_height 0x0, in_width 0x4, step_size 0x8,
// cell_size 0xC.
module strided_cell_sum import scs_pkg::*; #(
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_CELL     = DEF_MAX_CELL
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: row[5:0], col[11:6], channel[15:12], sample[31:16],
  //        out_row[37:32], out_col[43:38], zero pad [47:44]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command[0]
  input  logic                   s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: cell_sum[23:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // APB registers
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = SAMPLE_W + $clog2(MAX_CELL * MAX_CELL + 1);
  localparam int MW    = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int PROD_W = IDX_W + STEP_W;

  // ---------------------------------------------------------------- fields
  logic [IDX_W-1:0]    in_row, in_col, in_orow, in_ocol;
  logic [CHAN_W-1:0]   in_chan;
  logic [SAMPLE_W-1:0] in_sample;
  scs_cmd_e            in_cmd;

  assign in_row    = s_axis_tdata[5:0];
  assign in_col    = s_axis_tdata[11:6];
  assign in_chan   = s_axis_tdata[15:12];
  assign in_sample = s_axis_tdata[31:16];
  assign in_orow   = s_axis_tdata[37:32];
  assign in_ocol   = s_axis_tdata[43:38];
  assign in_cmd    = scs_cmd_e'(s_axis_tuser);

  // ------------------------------------------------------------- registers
  logic [DIM_W-1:0]  in_height_q, in_width_q;
  logic [STEP_W-1:0] step_size_q, cell_size_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= RST_IN_HEIGHT;
      in_width_q  <= RST_IN_WIDTH;
      step_size_q <= RST_STEP_SIZE;
      cell_size_q <= RST_CELL_SIZE;
    end else if (cfg_wr) begin
      case (scs_reg_e'(paddr[3:2]))
        REG_IN_HEIGHT: in_height_q <= pwdata[DIM_W-1:0];
        REG_IN_WIDTH:  in_width_q  <= pwdata[DIM_W-1:0];
        REG_STEP_SIZE: step_size_q <= pwdata[STEP_W-1:0];
        REG_CELL_SIZE: cell_size_q <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (scs_reg_e'(paddr[3:2]))
      REG_IN_HEIGHT: prdata = APB_DW'(in_height_q);
      REG_IN_WIDTH:  prdata = APB_DW'(in_width_q);
      REG_STEP_SIZE: prdata = APB_DW'(step_size_q);
      REG_CELL_SIZE: prdata = APB_DW'(cell_size_q);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- state
  scs_state_e state_q, state_d;
  logic       in_acc;
  logic       out_valid_q;
  logic [SUM_W-1:0] out_data_q;

  // fsm outputs
  logic s_ready, rd_en, acc_clr, out_load;

  // captured cell request
  logic [CHAN_W-1:0] chan_q;
  logic [IDX_W-1:0]  orow_q, ocol_q;

  // scan window and position
  logic [DIM_W-1:0] r1_q, c0_q, c1_q, r_q, c_q;
  logic             rd_valid_q;
  logic [ACC_W-1:0] acc_q;

  assign in_acc = s_axis_tvalid & s_ready;

  // window setup, from the captured request
  logic [DIM_W-1:0]  h_eff, w_eff;
  logic [STEP_W-1:0] cs_eff;
  logic [PROD_W-1:0] rprod, cprod;
  logic [DIM_W-1:0]  r0, r1, c0, c1;
  logic [DIM_W:0]    rend, cend;
  logic              chan_ok, win_empty, scan_last;

  always_comb begin
    h_eff  = (32'(in_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : in_height_q;
    w_eff  = (32'(in_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : in_width_q;
    cs_eff = (32'(cell_size_q) > MAX_CELL) ? STEP_W'(MAX_CELL) : cell_size_q;
    rprod  = PROD_W'(orow_q) * PROD_W'(step_size_q);
    cprod  = PROD_W'(ocol_q) * PROD_W'(step_size_q);
    r0     = (rprod >= PROD_W'(h_eff)) ? h_eff : rprod[DIM_W-1:0];
    c0     = (cprod >= PROD_W'(w_eff)) ? w_eff : cprod[DIM_W-1:0];
    rend   = (DIM_W+1)'(r0) + (DIM_W+1)'(cs_eff);
    cend   = (DIM_W+1)'(c0) + (DIM_W+1)'(cs_eff);
    r1     = (rend >= (DIM_W+1)'(h_eff)) ? h_eff : rend[DIM_W-1:0];
    c1     = (cend >= (DIM_W+1)'(w_eff)) ? w_eff : cend[DIM_W-1:0];
    chan_ok   = 32'(chan_q) < MAX_CHANNELS;
    win_empty = (r0 >= r1) || (c0 >= c1) || !chan_ok;
  end

  assign scan_last = (DIM_W'(r_q + 1'b1) == r1_q) && (DIM_W'(c_q + 1'b1) == c1_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_CELL) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = win_empty ? ST_FINISH : ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_ready  = 1'b0;
    rd_en    = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE:   s_ready  = 1'b1;
      ST_SETUP:  acc_clr  = 1'b1;
      ST_SCAN:   rd_en    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_axis_tready = s_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
    end
  end

  // request capture and scan position
  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_CELL) begin
      chan_q <= in_chan;
      orow_q <= in_orow;
      ocol_q <= in_ocol;
    end
    if (acc_clr) begin
      r_q  <= r0;
      c_q  <= c0;
      c0_q <= c0;
      c1_q <= c1;
      r1_q <= r1;
    end else if (rd_en) begin
      if (DIM_W'(c_q + 1'b1) == c1_q) begin
        c_q <= c0_q;
        r_q <= DIM_W'(r_q + 1'b1);
      end else begin
        c_q <= DIM_W'(c_q + 1'b1);
      end
    end
  end

  // ------------------------------------------------------------- store
  scs_mem_ctl_t        mem_ctl;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                wr_in_range;

  assign wr_in_range = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH) &&
                       (32'(in_chan) < MAX_CHANNELS);
  assign mem_ctl.we  = in_acc && in_cmd == CMD_WRITE && wr_in_range;
  assign mem_ctl.re  = rd_en;
  assign wr_addr = AW'((32'(in_chan) * MAX_HEIGHT + 32'(in_row)) * MAX_WIDTH
                       + 32'(in_col));
  assign rd_addr = AW'((32'(chan_q) * MAX_HEIGHT + 32'(r_q)) * MAX_WIDTH
                       + 32'(c_q));

  scs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_sample),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ------------------------------------------------------------- sum
  always_ff @(posedge clk_i) begin
    if (acc_clr) begin
      acc_q <= '0;
    end else if (rd_valid_q) begin
      acc_q <= acc_q + ACC_W'(rd_data);
    end
  end

  logic [MW-1:0]    acc_ext;
  logic [SUM_W-1:0] sum_sat;

  assign acc_ext = MW'(acc_q);
  assign sum_sat = (acc_ext > MW'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc_ext);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sum_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/scs_store.sv
// Sample store: one write port, one read port with registered read data.
module scs_store import scs_pkg::*; #(
  parameter int DEPTH = DEF_MAX_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  scs_mem_ctl_t        ctl_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [SAMPLE_W-1:0] wr_data_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [SAMPLE_W-1:0] rd_data_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/scs_checker.sv
// Port-level checks for the strided cell sum block, bound to the top level.
module scs_checker import scs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   pready
);

  // a stalled sum holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a sample write finishes in the cycle it is taken
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_WRITE |=> s_axis_tready)
    else $error("input not ready after a write word");

  // a cell request keeps the input side busy
  a_cell_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CELL |=> !s_axis_tready)
    else $error("input ready right after a cell word");

  // a sum needs at least setup and hand-off after its request
  a_cell_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CELL
      |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("cell finished too early");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind strided_cell_sum scs_checker u_scs_checker (.*);
